// ----- sv/bfd_pkg.sv -----
// Shared types and constants for the box filter downscaler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bfd_pkg;

  localparam int CW        = 13;
  localparam int DC_W      = 14;
  localparam int CNT_W     = 26;
  localparam int SUM_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_H = 3'd3;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [DC_W-1:0]  col;
    logic [11:0]      row;
    logic             first;
    logic             emit;
    logic             last;
    logic [CNT_W-1:0] count;
  } bfd_item_t;

endpackage

// ----- sv/box_filter_downscale_rgba8_core.sv -----
// Top level of the RGBA8 box filter downscaler.
// Depends on bfd_pkg, bfd_front, bfd_fifo and bfd_back.
//
// Source pixels enter in raster order on the in channel (valid/ready), one item
// per pixel. Each output item is the truncated per-channel mean of one source
// box, with its output column and row, and frame_last set on the frame's final
// output pixel. Sizes are set through the cfg channel, which is always ready;
// a write to a known register restarts the frame and holds in_ready_o low
// while the column and row step sizes are computed.
// The back end takes a pixel that closes no box through a read-modify-write of
// the column sum memory, and a pixel that closes a box also through the
// eight-step mean divider and the output register. It takes no new pixel until
// it is through with the last one. A two-entry queue lets the front keep
// taking pixels while the back end works. A stalled receiver holds the result
// in the output register; the back end waits behind it, then the queue fills.
// Reset gives a 1x1 source and destination and starts a new frame.
`timescale 1ns / 1ps

module box_filter_downscale_rgba8_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfd_pkg::CW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_red_i,
  input  logic [7:0]                    in_green_i,
  input  logic [7:0]                    in_blue_i,
  input  logic [7:0]                    in_alpha_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic [7:0]                    out_alpha_o,
  output logic [11:0]                   out_col_o,
  output logic [11:0]                   out_row_o,
  output logic                          frame_last_o
);
  import bfd_pkg::*;

  bfd_item_t push_item, pop_item;
  logic      push, pop, full, empty;

  bfd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_red_i, .in_green_i, .in_blue_i, .in_alpha_i,
    .full_i(full), .push_o(push), .item_o(push_item)
  );

  bfd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(push_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(pop_item)
  );

  bfd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(pop_item), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_red_o, .out_green_o, .out_blue_o,
    .out_alpha_o, .out_col_o, .out_row_o, .frame_last_o
  );

endmodule

// ----- sv/bfd_front.sv -----
// Front end: configuration registers, box edge stepping and pixel classification.
// Depends on bfd_pkg.
`timescale 1ns / 1ps

module bfd_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfd_pkg::CW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_red_i,
  input  logic [7:0]                    in_green_i,
  input  logic [7:0]                    in_blue_i,
  input  logic [7:0]                    in_alpha_i,
  input  logic                          full_i,
  output logic                          push_o,
  output bfd_pkg::bfd_item_t            item_o
);
  import bfd_pkg::*;

  typedef enum logic [1:0] {F_RUN, F_LOAD, F_DIV} front_state_e;

  front_state_e st_q;
  logic [CW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [CW-1:0] sw_eff, sh_eff, dw_eff, dh_eff;
  logic [CW-1:0] cq_q, cr_q, rq_q, rr_q;
  logic [CW-1:0] cnum_q, crem_q, rnum_q, rrem_q;
  logic [3:0]    cnt_q;
  logic [CW-1:0] col_q, row_q, col_start_q, col_end_q, col_rem_q;
  logic [CW-1:0] row_start_q, row_end_q, row_rem_q;
  logic [DC_W-1:0] dc_q;
  logic [CW-1:0] dr_q;
  logic          accept, cfg_hit;
  logic [CW:0]   ct, rt, csum, rsum;
  logic          cge, rge, ccarry, rcarry;
  logic [CW-1:0] cnum_s, crem_s, rnum_s, rrem_s;
  logic [CW-1:0] nc, nr, col_end_n, col_rem_n, row_end_n, row_rem_n;

  always_comb begin
    sw_eff = (src_w_q == '0) ? CW'(1) :
             (32'(src_w_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : src_w_q;
    sh_eff = (src_h_q == '0) ? CW'(1) :
             (32'(src_h_q) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : src_h_q;
    dw_eff = (dst_w_q == '0) ? CW'(1) : (dst_w_q > sw_eff) ? sw_eff : dst_w_q;
    dh_eff = (dst_h_q == '0) ? CW'(1) : (dst_h_q > sh_eff) ? sh_eff : dst_h_q;

    ct = {crem_q, cnum_q[CW-1]};
    cge = ct >= {1'b0, dw_eff};
    crem_s = cge ? CW'(ct - {1'b0, dw_eff}) : ct[CW-1:0];
    cnum_s = {cnum_q[CW-2:0], cge};
    rt = {rrem_q, rnum_q[CW-1]};
    rge = rt >= {1'b0, dh_eff};
    rrem_s = rge ? CW'(rt - {1'b0, dh_eff}) : rt[CW-1:0];
    rnum_s = {rnum_q[CW-2:0], rge};

    nc = col_q + 1'b1;
    nr = row_q + 1'b1;
    csum = {1'b0, col_rem_q} + {1'b0, cr_q};
    ccarry = csum >= {1'b0, dw_eff};
    col_end_n = col_end_q + cq_q + CW'(ccarry);
    col_rem_n = ccarry ? CW'(csum - {1'b0, dw_eff}) : csum[CW-1:0];
    rsum = {1'b0, row_rem_q} + {1'b0, rr_q};
    rcarry = rsum >= {1'b0, dh_eff};
    row_end_n = row_end_q + rq_q + CW'(rcarry);
    row_rem_n = rcarry ? CW'(rsum - {1'b0, dh_eff}) : rsum[CW-1:0];
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && (cfg_index_i == REG_SRC_W || cfg_index_i == REG_SRC_H ||
                       cfg_index_i == REG_DST_W || cfg_index_i == REG_DST_H);
  assign in_ready_o  = (st_q == F_RUN) && !full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign push_o      = accept;

  always_comb begin
    item_o.red   = in_red_i;
    item_o.green = in_green_i;
    item_o.blue  = in_blue_i;
    item_o.alpha = in_alpha_i;
    item_o.col   = dc_q;
    item_o.row   = dr_q[11:0];
    item_o.first = (row_q == row_start_q);
    item_o.emit  = (nc == col_end_q) && (nr == row_end_q);
    item_o.last  = (dc_q + 1'b1 == DC_W'(dw_eff)) && (nr - row_start_q != '0) &&
                   (dr_q + 1'b1 == dh_eff);
    item_o.count = (CNT_W)'(col_end_q - col_start_q) * (CNT_W)'(row_end_q - row_start_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_RUN;
      src_w_q <= CW'(1); src_h_q <= CW'(1); dst_w_q <= CW'(1); dst_h_q <= CW'(1);
      cq_q <= CW'(1); cr_q <= '0; rq_q <= CW'(1); rr_q <= '0;
      cnum_q <= '0; crem_q <= '0; rnum_q <= '0; rrem_q <= '0; cnt_q <= '0;
      col_q <= '0; row_q <= '0; dc_q <= '0; dr_q <= '0;
      col_start_q <= '0; col_end_q <= CW'(1); col_rem_q <= '0;
      row_start_q <= '0; row_end_q <= CW'(1); row_rem_q <= '0;
    end else if (cfg_hit) begin
      case (cfg_index_i)
        REG_SRC_W: src_w_q <= cfg_data_i;
        REG_SRC_H: src_h_q <= cfg_data_i;
        REG_DST_W: dst_w_q <= cfg_data_i;
        default:   dst_h_q <= cfg_data_i;
      endcase
      st_q <= F_LOAD;
    end else begin
      case (st_q)
        F_LOAD: begin
          cnum_q <= sw_eff; crem_q <= '0;
          rnum_q <= sh_eff; rrem_q <= '0;
          cnt_q  <= 4'(CW - 1);
          st_q   <= F_DIV;
        end
        F_DIV: begin
          cnum_q <= cnum_s; crem_q <= crem_s;
          rnum_q <= rnum_s; rrem_q <= rrem_s;
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            cq_q <= cnum_s; cr_q <= crem_s; rq_q <= rnum_s; rr_q <= rrem_s;
            col_q <= '0; row_q <= '0; dc_q <= '0; dr_q <= '0;
            col_start_q <= '0; col_end_q <= cnum_s; col_rem_q <= crem_s;
            row_start_q <= '0; row_end_q <= rnum_s; row_rem_q <= rrem_s;
            st_q <= F_RUN;
          end
        end
        default: begin
          if (accept) begin
            if (nc >= sw_eff) begin
              col_q <= '0; dc_q <= '0;
              col_start_q <= '0; col_end_q <= cq_q; col_rem_q <= cr_q;
              if (nr >= sh_eff) begin
                row_q <= '0; dr_q <= '0;
                row_start_q <= '0; row_end_q <= rq_q; row_rem_q <= rr_q;
              end else begin
                row_q <= nr;
                if (nr >= row_end_q) begin
                  dr_q <= dr_q + 1'b1;
                  row_start_q <= row_end_q;
                  row_end_q <= row_end_n;
                  row_rem_q <= row_rem_n;
                end
              end
            end else begin
              col_q <= nc;
              if (nc >= col_end_q) begin
                dc_q <= dc_q + 1'b1;
                col_start_q <= col_end_q;
                col_end_q <= col_end_n;
                col_rem_q <= col_rem_n;
              end
            end
          end
        end
      endcase
    end
  end

endmodule

// ----- sv/bfd_fifo.sv -----
// Two-entry queue of classified pixels between the front and back ends.
// Depends on bfd_pkg.
`timescale 1ns / 1ps

module bfd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bfd_pkg::bfd_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output bfd_pkg::bfd_item_t item_o
);
  import bfd_pkg::*;

  bfd_item_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; fill_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- sv/bfd_back.sv -----
// Back end: column sum memory update, mean division and the output register.
// Depends on bfd_pkg.
`timescale 1ns / 1ps

module bfd_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  bfd_pkg::bfd_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic [7:0]         out_alpha_o,
  output logic [11:0]        out_col_o,
  output logic [11:0]        out_row_o,
  output logic               frame_last_o
);
  import bfd_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [1:0] {B_IDLE, B_ACC, B_DIV, B_FIN} back_state_e;

  back_state_e      st_q;
  bfd_item_t        cur_q;
  logic [4*SUM_W-1:0] mem [MAX_WIDTH];
  logic [4*SUM_W-1:0] rdata_q, wdata;
  logic [SUM_W-1:0]   rem_q [4];
  logic [7:0]         quo_q [4];
  logic [SUM_W:0]     dvs_q;
  logic [2:0]         cnt_q;
  logic [7:0]         px [4];
  logic               ge [4];

  assign pop_o = (st_q == B_IDLE) && !empty_i;

  always_comb begin
    px[0] = cur_q.red; px[1] = cur_q.green; px[2] = cur_q.blue; px[3] = cur_q.alpha;
    for (int c = 0; c < 4; c++) begin
      wdata[c*SUM_W +: SUM_W] = cur_q.first ? SUM_W'(px[c]) :
                                rdata_q[c*SUM_W +: SUM_W] + SUM_W'(px[c]);
      ge[c] = {1'b0, rem_q[c]} >= dvs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == B_ACC) begin
      mem[cur_q.col[AW-1:0]] <= wdata;
    end
    if (pop_o) begin
      rdata_q <= mem[item_i.col[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
      cur_q <= '0;
      dvs_q <= '0;
      cnt_q <= '0;
      for (int c = 0; c < 4; c++) begin
        rem_q[c] <= '0; quo_q[c] <= '0;
      end
      out_valid_o <= 1'b0;
      out_red_o <= '0; out_green_o <= '0; out_blue_o <= '0; out_alpha_o <= '0;
      out_col_o <= '0; out_row_o <= '0; frame_last_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && st_q != B_FIN) out_valid_o <= 1'b0;
      case (st_q)
        B_IDLE: begin
          if (pop_o) begin
            cur_q <= item_i;
            st_q  <= B_ACC;
          end
        end
        B_ACC: begin
          if (cur_q.emit) begin
            for (int c = 0; c < 4; c++) begin
              rem_q[c] <= wdata[c*SUM_W +: SUM_W];
            end
            dvs_q <= (SUM_W + 1)'(cur_q.count) << 7;
            cnt_q <= 3'd7;
            st_q  <= B_DIV;
          end else begin
            st_q <= B_IDLE;
          end
        end
        B_DIV: begin
          for (int c = 0; c < 4; c++) begin
            if (ge[c]) rem_q[c] <= SUM_W'({1'b0, rem_q[c]} - dvs_q);
            quo_q[c] <= {quo_q[c][6:0], ge[c]};
          end
          dvs_q <= dvs_q >> 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) st_q <= B_FIN;
        end
        default: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o  <= 1'b1;
            out_red_o    <= quo_q[0];
            out_green_o  <= quo_q[1];
            out_blue_o   <= quo_q[2];
            out_alpha_o  <= quo_q[3];
            out_col_o    <= cur_q.col[11:0];
            out_row_o    <= cur_q.row;
            frame_last_o <= cur_q.last;
            st_q         <= B_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ----- sv/bfd_checker.sv -----
// Port-level checks for the box filter downscaler, bound to its top level.
// Depends on bfd_pkg and box_filter_downscale_rgba8_core.
`timescale 1ns / 1ps

module bfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [7:0]                    out_red_o,
  input logic [11:0]                   out_col_o,
  input logic [11:0]                   out_row_o,
  input logic                          frame_last_o
);
  import bfd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_red_o) && $stable(out_col_o) &&
    $stable(out_row_o) && $stable(frame_last_o)) else $error("result changed");

  a_cfg_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_SRC_W || cfg_index_i == REG_SRC_H ||
    cfg_index_i == REG_DST_W || cfg_index_i == REG_DST_H) |=> !in_ready_o ##1 !in_ready_o)
    else $error("pixel taken during setup");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o) else $error("result after reset");

endmodule

bind box_filter_downscale_rgba8_core bfd_checker u_bfd_checker (
  .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .in_ready_o,
  .out_valid_o, .out_ready_i, .out_red_o, .out_col_o, .out_row_o, .frame_last_o
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for box_filter_downscale_rgba8_core.
// Depends on bfd_pkg and the core; it streams pixels under directed and random sizes and
// checks every averaged pixel against its own box filter predictor.
`timescale 1ns / 1ps

module tb_top;
  import bfd_pkg::*;

  localparam int unsigned WMAX = 4096;
  localparam int unsigned HMAX = 4096;
  localparam int DRAIN = 40;

  typedef struct {
    logic [7:0]  red, green, blue, alpha;
    logic [11:0] col, row;
    logic        last;
  } box_mean_t;

  typedef struct {
    logic [31:0] pix;
    bit          typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] in_red_i = '0, in_green_i = '0, in_blue_i = '0, in_alpha_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic [11:0] out_col_o, out_row_o;
  logic frame_last_o;

  box_filter_downscale_rgba8_core dut (.clk_i(clk), .*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("box_filter_downscale_rgba8_core: mismatch");
    $finish;
  end

  box_mean_t pending_means[$];
  int errors = 0;
  bit no_idle = 0;
  bit long_hold = 0;

  logic [12:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  logic [31:0] col_sums[WMAX][4];
  int unsigned src_col, src_row, dst_col, dst_row;
  int unsigned col_end, row_start, row_end;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_sw();
    return clamp_size(src_w_reg, WMAX);
  endfunction
  function automatic int unsigned eff_sh();
    return clamp_size(src_h_reg, HMAX);
  endfunction
  function automatic int unsigned eff_dw();
    return clamp_size(dst_w_reg, eff_sw());
  endfunction
  function automatic int unsigned eff_dh();
    return clamp_size(dst_h_reg, eff_sh());
  endfunction

  function automatic int unsigned edge_at(int unsigned i, int unsigned s, int unsigned d);
    longint unsigned p;
    p = longint'(i) * longint'(s);
    return int'(p / d);
  endfunction

  function automatic void restart_frame();
    src_col = 0;
    src_row = 0;
    dst_col = 0;
    dst_row = 0;
    row_start = 0;
    col_end = edge_at(1, eff_sw(), eff_dw());
    row_end = edge_at(1, eff_sh(), eff_dh());
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [12:0] val);
    case (idx)
      REG_SRC_W: src_w_reg = val;
      REG_SRC_H: src_h_reg = val;
      REG_DST_W: dst_w_reg = val;
      REG_DST_H: dst_h_reg = val;
      default: return;
    endcase
    restart_frame();
  endfunction

  function automatic bit average_pixel(logic [31:0] pix, output box_mean_t m);
    int unsigned sw, sh, dw, dh, dc, cstart;
    longint unsigned cnt;
    logic [7:0] ch[4];
    bit hit;
    sw = eff_sw();
    sh = eff_sh();
    dw = eff_dw();
    dh = eff_dh();
    dc = (dst_col >= WMAX) ? WMAX - 1 : dst_col;
    ch[0] = pix[31:24];
    ch[1] = pix[23:16];
    ch[2] = pix[15:8];
    ch[3] = pix[7:0];
    for (int c = 0; c < 4; c++) begin
      if (src_row == row_start) col_sums[dc][c] = ch[c];
      else col_sums[dc][c] = col_sums[dc][c] + ch[c];
    end
    hit = (src_col + 1 == col_end) && (src_row + 1 == row_end);
    if (hit) begin
      cstart = edge_at(dc, sw, dw);
      cnt = longint'(col_end - cstart) * longint'(row_end - row_start);
      if (cnt == 0) cnt = 1;
      m.red = col_sums[dc][0] / cnt;
      m.green = col_sums[dc][1] / cnt;
      m.blue = col_sums[dc][2] / cnt;
      m.alpha = col_sums[dc][3] / cnt;
      m.col = dc[11:0];
      m.row = dst_row[11:0];
      m.last = (dc + 1 == dw) && (dst_row + 1 == dh);
    end
    src_col++;
    if (src_col >= col_end) begin
      dst_col = dc + 1;
      col_end = edge_at(dst_col + 1, sw, dw);
    end
    if (src_col >= sw) begin
      src_col = 0;
      dst_col = 0;
      col_end = edge_at(1, sw, dw);
      src_row++;
      if (src_row >= row_end) begin
        dst_row++;
        row_start = row_end;
        row_end = edge_at(dst_row + 1, sh, dh);
      end
      if (src_row >= sh) begin
        src_row = 0;
        dst_row = 0;
        row_start = 0;
        row_end = edge_at(1, sh, dh);
      end
    end
    return hit;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    box_mean_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_means.size() == 0) begin
        report_mismatch("unexpected item, col", out_col_o, -1);
      end else begin
        e = pending_means.pop_front();
        if (out_red_o !== e.red) report_mismatch("red", out_red_o, e.red);
        if (out_green_o !== e.green) report_mismatch("green", out_green_o, e.green);
        if (out_blue_o !== e.blue) report_mismatch("blue", out_blue_o, e.blue);
        if (out_alpha_o !== e.alpha) report_mismatch("alpha", out_alpha_o, e.alpha);
        if (out_col_o !== e.col) report_mismatch("col", out_col_o, e.col);
        if (out_row_o !== e.row) report_mismatch("row", out_row_o, e.row);
        if (frame_last_o !== e.last) report_mismatch("frame_last", frame_last_o, e.last);
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold && hold == 0) hold = 400;
      if (hold > 0) begin
        hold--;
        if (hold == 0) long_hold = 0;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk); while (!cfg_ready_o);
    @(posedge clk);
    apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_sizes(logic [12:0] sw, logic [12:0] sh, logic [12:0] dw,
                             logic [12:0] dh);
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_DST_W, dw);
    write_reg(REG_DST_H, dh);
  endtask

  task automatic send_pixel(logic [31:0] pix, bit typed);
    box_mean_t m;
    in_valid_i <= 1'b1;
    {in_red_i, in_green_i, in_blue_i, in_alpha_i} <= pix;
    do @(negedge clk); while (!in_ready_o);
    @(posedge clk);
    if (average_pixel(pix, m)) begin
      if (typed) begin
        m = '{pix[31:24], pix[23:16], pix[15:8], pix[7:0], 12'd0, 12'd0, 1'b1};
      end
      pending_means.push_back(m);
    end
    if (!no_idle && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  stim_row_t directed[] = '{
    '{32'h00000000, 1}, '{32'hFFFFFFFF, 1}, '{32'h55AA55AA, 1}, '{32'hAA55AA55, 1},
    '{32'h01020408, 1}, '{32'h80402010, 1},
    '{32'hFF000000, 0}, '{32'h00FF0000, 0}, '{32'h0000FF00, 0}, '{32'h000000FF, 0},
    '{32'hFFFFFFFF, 0}, '{32'h01010101, 0}, '{32'h7F7F7F7F, 0}, '{32'hFEFEFEFE, 0},
    '{32'h12345678, 0}, '{32'h9ABCDEF0, 0}, '{32'hFFFFFFFF, 0}, '{32'h00000000, 0}
  };

  initial begin
    int sent, phase, n, sw, sh;
    logic [12:0] w, h, dw, dh;
    src_w_reg = 1;
    src_h_reg = 1;
    dst_w_reg = 1;
    dst_h_reg = 1;
    foreach (col_sums[i, c]) col_sums[i][c] = '0;
    restart_frame();
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (i == 6) begin
        settle();
        write_sizes(13'd3, 13'd4, 13'd2, 13'd3);
      end
      send_pixel(directed[i].pix, directed[i].typed);
    end
    settle();

    sent = 0;
    phase = 0;
    while (sent < 950) begin
      if (phase % 7 == 3) begin
        w = 13'd8191; h = 13'd0; dw = 13'd8191; dh = 13'd5; n = 48;
      end else if (phase % 7 == 5) begin
        w = 13'd4096; h = 13'd2; dw = (phase % 2) ? 13'd0 : 13'd3; dh = 13'd1; n = 40;
      end else begin
        w = $urandom_range(0, 9);
        h = $urandom_range(0, 6);
        dw = $urandom_range(0, w + 2);
        dh = $urandom_range(0, h + 2);
        sw = (w == 0) ? 1 : w;
        sh = (h == 0) ? 1 : h;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : sw * sh * $urandom_range(1, 3);
      end
      write_sizes(w, h, dw, dh);
      if (phase % 5 == 2) write_reg(CFG_IDX_W'($urandom_range(4, 7)), 13'($urandom));
      no_idle = (phase == 4 || phase == 5);
      if (phase == 3) long_hold = 1;
      for (int k = 0; k < n; k++) send_pixel($urandom, 0);
      sent += n;
      settle();
      phase++;
    end
    no_idle = 0;

    if (errors == 0) begin
      $display("box_filter_downscale_rgba8_core: match");
    end else begin
      $display("box_filter_downscale_rgba8_core: mismatch");
    end
    $finish;
  end

endmodule
